// ----- rtl/core/dsm_pkg.sv -----
package dsm_pkg;

    // Status bit positions inside an entry's status word
    localparam int ST_FAILED  = 0;
    localparam int ST_CONFIRM = 1;
    localparam int ST_FTC     = 2;
    localparam int ST_NOTDONE = 3;
    localparam int ST_WARN    = 4;
    localparam int ST_FFLAG   = 5;

    localparam logic [7:0] OCC_MAX = 8'd255;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_FAILED_THRESHOLD = 3'd0,
        CFG_PASSED_THRESHOLD = 3'd1,
        CFG_SAMPLE_PERIOD    = 3'd2,
        CFG_AUTO_RESTORE     = 3'd3,
        CFG_WARNING_ENABLE   = 3'd4,
        CFG_CRITICAL_ENABLE  = 3'd5
    } cfg_idx_t;

    // Test result codes
    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_FAILED = 2'd1,
        RES_PASSED = 2'd2
    } test_result_t;

    typedef struct packed {
        logic [6:0]        failed_threshold;
        logic signed [7:0] passed_threshold;
        logic [7:0]        sample_period;
        logic              auto_restore;
        logic              warning_enable;
        logic              critical_enable;
    } cfg_t;

    // One entry of the state memory
    typedef struct packed {
        logic [7:0]        prescale;
        logic signed [7:0] debounce;
        logic [5:0]        status;
        logic [7:0]        category;
        logic [7:0]        occurrence;
    } entry_state_t;

    localparam entry_state_t ENTRY_RESET = '{
        prescale:   8'd0,
        debounce:   8'sd0,
        status:     6'b001000,
        category:   8'd0,
        occurrence: 8'd0
    };

    // Outcome of one evaluation step
    typedef struct packed {
        logic         sampled;
        test_result_t result;
        logic         critical;
    } step_info_t;

endpackage

// ----- rtl/core/dsm_sample_if.sv -----
interface dsm_sample_if;
    logic       valid;
    logic       ready;
    logic [3:0] entry;
    logic       test_enabled;
    logic       fault_present;
    logic [7:0] fault_category;

    modport source (
        output valid, entry, test_enabled, fault_present, fault_category,
        input  ready
    );
    modport sink (
        input  valid, entry, test_enabled, fault_present, fault_category,
        output ready
    );
endinterface

// ----- rtl/core/dsm_result_if.sv -----
interface dsm_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] out_entry;
    logic       sampled;
    logic [1:0] test_result;
    logic       fault_flag;
    logic       test_failed;
    logic       confirmed;
    logic       failed_this_cycle;
    logic       not_completed;
    logic       warning_request;
    logic       critical_request;
    logic [7:0] stored_category;
    logic [7:0] occurrence_count;

    modport source (
        output valid, out_entry, sampled, test_result, fault_flag, test_failed, confirmed,
               failed_this_cycle, not_completed, warning_request, critical_request,
               stored_category, occurrence_count,
        input  ready
    );
    modport sink (
        input  valid, out_entry, sampled, test_result, fault_flag, test_failed, confirmed,
               failed_this_cycle, not_completed, warning_request, critical_request,
               stored_category, occurrence_count,
        output ready
    );
endinterface

// ----- rtl/core/dsm_ram.sv -----
module dsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a same-address read returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/dsm_cfg_regs.sv -----
module dsm_cfg_regs (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    output dsm_pkg::cfg_t  cfg
);

    dsm_pkg::cfg_t cfg_reg;
    dsm_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (dsm_pkg::cfg_idx_t'(cfg_index))
                dsm_pkg::CFG_FAILED_THRESHOLD: cfg_next.failed_threshold = cfg_data[6:0];
                dsm_pkg::CFG_PASSED_THRESHOLD: cfg_next.passed_threshold = signed'(cfg_data);
                dsm_pkg::CFG_SAMPLE_PERIOD:    cfg_next.sample_period    = cfg_data;
                dsm_pkg::CFG_AUTO_RESTORE:     cfg_next.auto_restore     = cfg_data[0];
                dsm_pkg::CFG_WARNING_ENABLE:   cfg_next.warning_enable   = cfg_data[0];
                dsm_pkg::CFG_CRITICAL_ENABLE:  cfg_next.critical_enable  = cfg_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.failed_threshold <= 7'd5;
            cfg_reg.passed_threshold <= -8'sd5;
            cfg_reg.sample_period    <= 8'd1;
            cfg_reg.auto_restore     <= 1'b0;
            cfg_reg.warning_enable   <= 1'b0;
            cfg_reg.critical_enable  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/dsm_update.sv -----
module dsm_update (
    input  dsm_pkg::entry_state_t cur,
    input  logic                  test_enabled,
    input  logic                  fault_present,
    input  logic [7:0]            fault_category,
    input  dsm_pkg::cfg_t         cfg,
    output dsm_pkg::entry_state_t nxt,
    output dsm_pkg::step_info_t   info
);

    logic [8:0]        pc;
    logic signed [7:0] ft_s;
    logic              first_fail;

    assign pc         = {1'b0, cur.prescale} + 9'd1;
    assign ft_s       = signed'({1'b0, cfg.failed_threshold});
    assign first_fail = !cur.status[dsm_pkg::ST_FTC];

    // Advance the prescaler, then debounce and update status on a sample
    always_comb
    begin
        nxt           = cur;
        info.sampled  = 1'b0;
        info.result   = dsm_pkg::RES_NONE;
        info.critical = 1'b0;

        if (test_enabled)
        begin
            if (pc >= {1'b0, cfg.sample_period})
            begin
                nxt.prescale = 8'd0;
                info.sampled = 1'b1;
            end
            else
            begin
                nxt.prescale = pc[7:0];
            end
        end

        if (info.sampled)
        begin
            if (fault_present)
            begin
                if (cur.debounce < ft_s)
                begin
                    nxt.debounce = cur.debounce[7] ? 8'sd1 : cur.debounce + 8'sd1;
                end
                else if (!cur.status[dsm_pkg::ST_FAILED])
                begin
                    nxt.status[dsm_pkg::ST_FAILED]  = 1'b1;
                    nxt.status[dsm_pkg::ST_CONFIRM] = 1'b1;
                    nxt.status[dsm_pkg::ST_FTC]     = 1'b1;
                    nxt.status[dsm_pkg::ST_FFLAG]   = 1'b1;
                    nxt.status[dsm_pkg::ST_NOTDONE] = 1'b0;
                    nxt.status[dsm_pkg::ST_WARN]    = cfg.warning_enable;
                    info.critical = cfg.critical_enable;
                    info.result   = dsm_pkg::RES_FAILED;
                    if (first_fail)
                    begin
                        nxt.category = fault_category;
                        if (cur.occurrence != dsm_pkg::OCC_MAX)
                        begin
                            nxt.occurrence = cur.occurrence + 8'd1;
                        end
                    end
                end
            end
            else
            begin
                if (cur.debounce > cfg.passed_threshold)
                begin
                    nxt.debounce = cur.debounce - 8'sd1;
                end
                else if (cur.status[dsm_pkg::ST_FAILED] || cur.status[dsm_pkg::ST_NOTDONE])
                begin
                    nxt.status[dsm_pkg::ST_FAILED]  = 1'b0;
                    nxt.status[dsm_pkg::ST_NOTDONE] = 1'b0;
                    nxt.status[dsm_pkg::ST_FFLAG]   = 1'b0;
                    if (cfg.auto_restore)
                    begin
                        nxt.status[dsm_pkg::ST_FTC] = 1'b0;
                    end
                    info.result = dsm_pkg::RES_PASSED;
                end
            end
        end
    end

endmodule

// ----- rtl/core/dtc_debounce_status_manager.sv -----
// Debounce and status manager for NUM_ENTRIES diagnostic trouble code entries. Each sample
// transfer names an entry; its state (prescaler, debounce counter, status bits, category,
// occurrence count) lives in one state RAM with a registered read. An accepted sample
// reads its entry; the update stage then updates it, writes it back and loads the result
// register. A new sample is taken every cycle while the result side keeps up. A last-write
// register forwards freshly updated state to a back-to-back sample of the same entry, and
// per-entry written bits make never-touched entries read as their reset state, so no
// clearing pass is needed after reset. The user must write configuration through the plain
// write port only while the block is idle; the block itself does not enforce this.
module dtc_debounce_status_manager #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    dsm_sample_if.sink          sample,
    dsm_result_if.source        result,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    localparam int IDX_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int STATE_W = $bits(dsm_pkg::entry_state_t);

    dsm_pkg::cfg_t         cfg;
    dsm_pkg::entry_state_t ram_q;
    dsm_pkg::entry_state_t cur;
    dsm_pkg::entry_state_t nxt;
    dsm_pkg::step_info_t   info;

    logic       accept;
    logic       s1_go;
    logic       s1_inrange;
    logic [IDX_W-1:0] s1_idx;
    logic       ram_we;

    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [3:0] s1_entry_reg;
    logic       s1_en_reg;
    logic       s1_fault_reg;
    logic [7:0] s1_cat_reg;

    logic [NUM_ENTRIES-1:0] written_reg;
    logic                   lw_valid_reg;
    logic [IDX_W-1:0]       lw_idx_reg;
    dsm_pkg::entry_state_t  lw_data_reg;

    logic       res_valid_reg;
    logic       res_valid_next;
    logic [3:0] res_entry_reg;
    logic       res_sampled_reg;
    logic [1:0] res_result_reg;
    logic [5:0] res_status_reg;
    logic       res_crit_reg;
    logic [7:0] res_cat_reg;
    logic [7:0] res_occ_reg;

    dsm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the update stage moves on when the result register is free or drains
    assign s1_go        = !res_valid_reg || result.ready;
    assign sample.ready = !s1_valid_reg || s1_go;
    assign accept       = sample.valid && sample.ready;

    assign s1_idx     = IDX_W'(s1_entry_reg);
    assign s1_inrange = (32'(s1_entry_reg) < NUM_ENTRIES);
    assign ram_we     = s1_valid_reg && s1_go && s1_inrange;

    dsm_ram #(
        .WIDTH (STATE_W),
        .DEPTH (NUM_ENTRIES)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_idx),
        .wdata (nxt),
        .re    (accept),
        .raddr (IDX_W'(sample.entry)),
        .rdata (ram_q)
    );

    // Pick the current entry state: forwarded write, stored data, or reset value
    always_comb
    begin
        if (lw_valid_reg && (lw_idx_reg == s1_idx))
        begin
            cur = lw_data_reg;
        end
        else if (written_reg[s1_idx])
        begin
            cur = ram_q;
        end
        else
        begin
            cur = dsm_pkg::ENTRY_RESET;
        end
    end

    dsm_update u_update (
        .cur            (cur),
        .test_enabled   (s1_en_reg),
        .fault_present  (s1_fault_reg),
        .fault_category (s1_cat_reg),
        .cfg            (cfg),
        .nxt            (nxt),
        .info           (info)
    );

    // Stage and output valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (s1_valid_reg && s1_go)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (ram_we)
            begin
                lw_valid_reg        <= 1'b1;
                written_reg[s1_idx] <= 1'b1;
            end
        end
    end

    // Payload: capture the sample, track the last write, load the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_entry_reg <= sample.entry;
            s1_en_reg    <= sample.test_enabled;
            s1_fault_reg <= sample.fault_present;
            s1_cat_reg   <= sample.fault_category;
        end
        if (ram_we)
        begin
            lw_idx_reg  <= s1_idx;
            lw_data_reg <= nxt;
        end
        if (s1_valid_reg && s1_go)
        begin
            res_entry_reg <= s1_entry_reg;
            if (s1_inrange)
            begin
                res_sampled_reg <= info.sampled;
                res_result_reg  <= info.result;
                res_status_reg  <= nxt.status;
                res_crit_reg    <= info.critical;
                res_cat_reg     <= nxt.category;
                res_occ_reg     <= nxt.occurrence;
            end
            else
            begin
                res_sampled_reg <= 1'b0;
                res_result_reg  <= dsm_pkg::RES_NONE;
                res_status_reg  <= '0;
                res_crit_reg    <= 1'b0;
                res_cat_reg     <= '0;
                res_occ_reg     <= '0;
            end
        end
    end

    // Drive the result channel
    assign result.valid             = res_valid_reg;
    assign result.out_entry         = res_entry_reg;
    assign result.sampled           = res_sampled_reg;
    assign result.test_result       = res_result_reg;
    assign result.fault_flag        = res_status_reg[dsm_pkg::ST_FFLAG];
    assign result.test_failed       = res_status_reg[dsm_pkg::ST_FAILED];
    assign result.confirmed         = res_status_reg[dsm_pkg::ST_CONFIRM];
    assign result.failed_this_cycle = res_status_reg[dsm_pkg::ST_FTC];
    assign result.not_completed     = res_status_reg[dsm_pkg::ST_NOTDONE];
    assign result.warning_request   = res_status_reg[dsm_pkg::ST_WARN];
    assign result.critical_request  = res_crit_reg;
    assign result.stored_category   = res_cat_reg;
    assign result.occurrence_count  = res_occ_reg;

endmodule

// ----- test/dtc_debounce_status_manager_tb.sv -----
module dtc_debounce_status_manager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 20;
    localparam int NUM_ENTRIES = 16;
    localparam int LATENCY     = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SHOWN_FAILS = 10;

    // One result transfer as the checker sees it
    typedef struct packed {
        logic [3:0]            entry;
        logic                  sampled;
        dsm_pkg::test_result_t verdict;
        logic                  fault_flag;
        logic                  test_failed;
        logic                  confirmed;
        logic                  failed_this_cycle;
        logic                  not_completed;
        logic                  warning_request;
        logic                  critical_request;
        logic [7:0]            category;
        logic [7:0]            occurrences;
    } dtc_report_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    dsm_sample_if sample_ch ();
    dsm_result_if result_ch ();

    // Predictor copy of the entry table and the configuration
    dsm_pkg::entry_state_t dtc_state [NUM_ENTRIES];
    dsm_pkg::cfg_t         cfg_shadow;
    dtc_report_t           expected_reports [$];

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   fail_count  = 0;
    int   cycle_count = 0;
    logic rx_hold     = 1'b0;
    event hold_go;

    dtc_debounce_status_manager #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .result   (result_ch),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advance one entry through prescaler, debounce counter and status update
    function automatic dtc_report_t debounce_step(input logic [3:0] e, input logic en,
                                                  input logic f, input logic [7:0] cat);
        dsm_pkg::entry_state_t s;
        dtc_report_t           r;
        logic [8:0]            tick;
        int                    cnt;
        s = dtc_state[e];
        r = '0;
        r.entry = e;
        r.verdict = dsm_pkg::RES_NONE;
        if (en)
        begin
            tick = {1'b0, s.prescale} + 9'd1;
            if (tick >= {1'b0, cfg_shadow.sample_period})
            begin
                s.prescale = 8'd0;
                r.sampled = 1'b1;
            end
            else
            begin
                s.prescale = tick[7:0];
            end
        end
        if (r.sampled)
        begin
            cnt = int'($signed(s.debounce));
            if (f)
            begin
                if (cnt < int'(cfg_shadow.failed_threshold))
                begin
                    cnt = (cnt < 0) ? 1 : cnt + 1;
                end
                else if (!s.status[dsm_pkg::ST_FAILED])
                begin
                    // first failure of the operation cycle latches the category
                    if (!s.status[dsm_pkg::ST_FTC])
                    begin
                        s.category = cat;
                        if (s.occurrence != dsm_pkg::OCC_MAX)
                            s.occurrence = s.occurrence + 8'd1;
                    end
                    s.status[dsm_pkg::ST_FAILED]  = 1'b1;
                    s.status[dsm_pkg::ST_CONFIRM] = 1'b1;
                    s.status[dsm_pkg::ST_FTC]     = 1'b1;
                    s.status[dsm_pkg::ST_FFLAG]   = 1'b1;
                    s.status[dsm_pkg::ST_NOTDONE] = 1'b0;
                    s.status[dsm_pkg::ST_WARN]    = cfg_shadow.warning_enable;
                    r.critical_request = cfg_shadow.critical_enable;
                    r.verdict = dsm_pkg::RES_FAILED;
                end
            end
            else
            begin
                if (cnt > int'($signed(cfg_shadow.passed_threshold)))
                begin
                    cnt = cnt - 1;
                end
                else if (s.status[dsm_pkg::ST_FAILED] || s.status[dsm_pkg::ST_NOTDONE])
                begin
                    s.status[dsm_pkg::ST_FAILED]  = 1'b0;
                    s.status[dsm_pkg::ST_NOTDONE] = 1'b0;
                    s.status[dsm_pkg::ST_FFLAG]   = 1'b0;
                    if (cfg_shadow.auto_restore)
                        s.status[dsm_pkg::ST_FTC] = 1'b0;
                    r.verdict = dsm_pkg::RES_PASSED;
                end
            end
            s.debounce = cnt[7:0];
        end
        dtc_state[e] = s;
        r.fault_flag        = s.status[dsm_pkg::ST_FFLAG];
        r.test_failed       = s.status[dsm_pkg::ST_FAILED];
        r.confirmed         = s.status[dsm_pkg::ST_CONFIRM];
        r.failed_this_cycle = s.status[dsm_pkg::ST_FTC];
        r.not_completed     = s.status[dsm_pkg::ST_NOTDONE];
        r.warning_request   = s.status[dsm_pkg::ST_WARN];
        r.category          = s.category;
        r.occurrences       = s.occurrence;
        return r;
    endfunction

    // Offer one sample, hold it until the transfer, then record the expected report
    task automatic send_sample(input logic [3:0] e, input logic en, input logic f,
                               input logic [7:0] cat);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.entry          <= e;
        sample_ch.test_enabled   <= en;
        sample_ch.fault_present  <= f;
        sample_ch.fault_category <= cat;
        do
            @(posedge clk);
        while (sample_ch.ready !== 1'b1);
        expected_reports.push_back(debounce_step(e, en, f, cat));
    endtask

    // Drop valid and wait until every expected report has come back
    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input dsm_pkg::cfg_idx_t idx, input logic [7:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write all registers in one burst while the block is idle
    task automatic configure(input logic [6:0] ft, input logic [7:0] pt, input logic [7:0] sp,
                             input logic ar, input logic we, input logic ce);
        wait_for_results();
        write_reg(dsm_pkg::CFG_FAILED_THRESHOLD, {1'b0, ft});
        write_reg(dsm_pkg::CFG_PASSED_THRESHOLD, pt);
        write_reg(dsm_pkg::CFG_SAMPLE_PERIOD, sp);
        write_reg(dsm_pkg::CFG_AUTO_RESTORE, {7'd0, ar});
        write_reg(dsm_pkg::CFG_WARNING_ENABLE, {7'd0, we});
        write_reg(dsm_pkg::CFG_CRITICAL_ENABLE, {7'd0, ce});
        cfg_wr_en <= 1'b0;
        cfg_shadow.failed_threshold = ft;
        cfg_shadow.passed_threshold = pt;
        cfg_shadow.sample_period    = sp;
        cfg_shadow.auto_restore     = ar;
        cfg_shadow.warning_enable   = we;
        cfg_shadow.critical_enable  = ce;
    endtask

    // Reset thresholds: five counts up, the sixth fault sample fails
    task automatic test_reset_thresholds();
        repeat (6) send_sample(4'd5, 1'b1, 1'b1, 8'h3C);
    endtask

    // Zero thresholds: pass from not completed, repeat pass and fail, auto-restore
    task automatic test_pass_fail_edges();
        configure(7'd0, 8'sd0, 8'd1, 1'b1, 1'b1, 1'b1);
        send_sample(4'd15, 1'b1, 1'b0, 8'h00);
        send_sample(4'd15, 1'b1, 1'b0, 8'h00);
        send_sample(4'd15, 1'b1, 1'b1, 8'hFF);
        send_sample(4'd15, 1'b1, 1'b1, 8'h11);
        send_sample(4'd15, 1'b0, 1'b1, 8'hAA);
        send_sample(4'd15, 1'b1, 1'b0, 8'h00);
        send_sample(4'd15, 1'b1, 1'b1, 8'h5A);
    endtask

    // Zero period samples every input; a negative count jumps to one on a fault
    task automatic test_negative_jump();
        configure(7'd1, 8'h80, 8'd0, 1'b0, 1'b0, 1'b0);
        send_sample(4'd0, 1'b1, 1'b0, 8'h01);
        send_sample(4'd0, 1'b1, 1'b0, 8'h02);
        send_sample(4'd0, 1'b1, 1'b1, 8'h03);
        send_sample(4'd0, 1'b1, 1'b1, 8'h04);
        send_sample(4'd0, 1'b1, 1'b0, 8'h05);
    endtask

    // Lower the period below the running prescale count
    task automatic test_period_change();
        configure(7'd127, 8'h80, 8'd255, 1'b0, 1'b1, 1'b0);
        repeat (3) send_sample(4'd3, 1'b1, 1'b1, 8'h77);
        configure(7'd127, 8'h80, 8'd2, 1'b0, 1'b1, 1'b0);
        send_sample(4'd3, 1'b1, 1'b1, 8'h78);
    endtask

    // Fail and pass one entry until the occurrence count saturates
    task automatic test_occurrence_saturation();
        configure(7'd0, 8'sd0, 8'd1, 1'b1, 1'b0, 1'b1);
        repeat (260)
        begin
            send_sample(4'd7, 1'b1, 1'b1, 8'($urandom_range(255)));
            send_sample(4'd7, 1'b1, 1'b0, 8'($urandom_range(255)));
        end
    endtask

    // Runs of one fault level on one entry, with some noise between them
    task automatic test_random_traffic(input int rounds, input int per_round);
        logic [6:0] ft;
        logic [7:0] sp;
        int         ptv;
        int         pick;
        int         sent;
        int         lim;
        int         len;
        logic [3:0] e;
        logic       f;
        for (int k = 0; k < rounds; k++)
        begin
            pick = $urandom_range(9);
            ft = (pick < 6) ? 7'($urandom_range(4)) :
                 (pick < 9) ? 7'($urandom_range(12, 5)) : 7'd127;
            pick = $urandom_range(9);
            ptv = (pick < 5) ? 0 - int'($urandom_range(4)) :
                  (pick < 8) ? 0 - int'($urandom_range(12, 5)) : -128;
            pick = $urandom_range(19);
            sp = (pick < 12) ? 8'd1 : (pick < 15) ? 8'd0 :
                 (pick < 19) ? 8'($urandom_range(3, 2)) : 8'($urandom_range(255, 4));
            configure(ft, ptv[7:0], sp, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
            sent = 0;
            while (sent < per_round)
            begin
                if ($urandom_range(9) < 8)
                begin
                    e = 4'($urandom_range(15));
                    f = 1'($urandom_range(1));
                    lim = (int'(ft) + 3) * ((sp == 8'd0) ? 1 : int'(sp));
                    if (lim > 40)
                        lim = 40;
                    len = $urandom_range(lim, 1);
                    if (len > per_round - sent)
                        len = per_round - sent;
                    repeat (len)
                        send_sample(e, ($urandom_range(19) != 0), f, 8'($urandom_range(255)));
                    sent += len;
                end
                else
                begin
                    send_sample(4'($urandom_range(15)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), 8'($urandom_range(255)));
                    sent++;
                end
            end
        end
    endtask

    // Hold off the result side for a long stretch while samples keep coming
    task automatic test_output_backpressure();
        logic [3:0] e;
        configure(7'd2, 8'hFE, 8'd1, 1'b1, 1'b1, 1'b1);
        -> hold_go;
        repeat (12)
        begin
            e = 4'($urandom_range(15));
            repeat (5) send_sample(e, 1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    // Long receiver hold-off, timed here
    initial
    begin
        forever
        begin
            @(hold_go);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // Check each result transfer against the oldest expected report
    initial
    begin
        dtc_report_t got;
        dtc_report_t want;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                got.entry             = result_ch.out_entry;
                got.sampled           = result_ch.sampled;
                got.verdict           = dsm_pkg::test_result_t'(result_ch.test_result);
                got.fault_flag        = result_ch.fault_flag;
                got.test_failed       = result_ch.test_failed;
                got.confirmed         = result_ch.confirmed;
                got.failed_this_cycle = result_ch.failed_this_cycle;
                got.not_completed     = result_ch.not_completed;
                got.warning_request   = result_ch.warning_request;
                got.critical_request  = result_ch.critical_request;
                got.category          = result_ch.stored_category;
                got.occurrences       = result_ch.occurrence_count;
                if (expected_reports.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_FAILS)
                        $display("unexpected result transfer for entry %0d", got.entry);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= SHOWN_FAILS)
                        begin
                            $display("result mismatch entry %0d", want.entry);
                            $display("  expected: smp %b res %0d ff/tf/cf/ftc/nc/wr/cr %b cat %0d occ %0d",
                                     want.sampled, want.verdict,
                                     {want.fault_flag, want.test_failed, want.confirmed,
                                      want.failed_this_cycle, want.not_completed,
                                      want.warning_request, want.critical_request},
                                     want.category, want.occurrences);
                            $display("  actual:   smp %b res %0d ff/tf/cf/ftc/nc/wr/cr %b cat %0d occ %0d",
                                     got.sampled, got.verdict,
                                     {got.fault_flag, got.test_failed, got.confirmed,
                                      got.failed_this_cycle, got.not_completed,
                                      got.warning_request, got.critical_request},
                                     got.category, got.occurrences);
                        end
                    end
                end
            end
            if (rx_hold)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Bound the run
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("dtc_debounce_status_manager verification failed");
        $finish;
    end

    initial
    begin
        rst_n                    <= 1'b0;
        cfg_wr_en                <= 1'b0;
        cfg_index                <= dsm_pkg::CFG_FAILED_THRESHOLD;
        cfg_data                 <= 8'd0;
        sample_ch.valid          <= 1'b0;
        sample_ch.entry          <= 4'd0;
        sample_ch.test_enabled   <= 1'b0;
        sample_ch.fault_present  <= 1'b0;
        sample_ch.fault_category <= 8'd0;
        for (int i = 0; i < NUM_ENTRIES; i++)
            dtc_state[i] = dsm_pkg::ENTRY_RESET;
        cfg_shadow.failed_threshold = 7'd5;
        cfg_shadow.passed_threshold = -8'sd5;
        cfg_shadow.sample_period    = 8'd1;
        cfg_shadow.auto_restore     = 1'b0;
        cfg_shadow.warning_enable   = 1'b0;
        cfg_shadow.critical_enable  = 1'b0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 30;
        rx_idle_pct = 85;
        test_reset_thresholds();
        test_pass_fail_edges();
        test_negative_jump();
        test_period_change();
        test_occurrence_saturation();

        tx_idle_pct = 85;
        rx_idle_pct = 30;
        test_random_traffic(8, 50);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_output_backpressure();
        test_random_traffic(8, 45);

        wait_for_results();
        fail_count += expected_reports.size();
        if (fail_count == 0)
            $display("dtc_debounce_status_manager verification clean");
        else
            $display("dtc_debounce_status_manager verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/dsm_pkg.sv
rtl/core/dsm_sample_if.sv
rtl/core/dsm_result_if.sv
rtl/core/dsm_ram.sv
rtl/core/dsm_cfg_regs.sv
rtl/core/dsm_update.sv
rtl/core/dtc_debounce_status_manager.sv
test/dtc_debounce_status_manager_tb.sv
